// ===== hdl/dgst_pkg.sv =====
// Shared types and codes for the dual gear shift tracker.
// No dependencies; compile first.
`timescale 1ns / 1ps
`default_nettype none

package dgst_pkg;

  // Per-side gear state, as presented on the result channel
  typedef enum logic [1:0] {
    GEAR_LOW  = 2'd0,
    GEAR_HIGH = 2'd1,
    GEAR_UP   = 2'd2,
    GEAR_DOWN = 2'd3
  } gear_t;

  // Item kind on the input channel
  typedef enum logic {
    REQ_GEAR   = 1'b0,
    REQ_SAMPLE = 1'b1
  } req_t;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 3;
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CLUTCH_MODE      = 3'd0,
    CFG_LEFT_CLEAR_LOW   = 3'd1,
    CFG_LEFT_CLEAR_HIGH  = 3'd2,
    CFG_RIGHT_CLEAR_LOW  = 3'd3,
    CFG_RIGHT_CLEAR_HIGH = 3'd4
  } cfg_idx_t;

  // Move one side toward the requested gear
  function automatic gear_t next_gear(input logic want_high, input logic clutch,
                                      input gear_t cur);
    gear_t target;
    gear_t res;
    target = want_high ? GEAR_HIGH : GEAR_LOW;
    res    = cur;
    if (cur != target) begin
      case (cur)
        GEAR_LOW, GEAR_HIGH: begin
          if (want_high) res = clutch ? GEAR_HIGH : GEAR_UP;
          else           res = clutch ? GEAR_LOW : GEAR_DOWN;
        end
        GEAR_DOWN: if (want_high) res = GEAR_UP;
        GEAR_UP:   if (!want_high) res = GEAR_DOWN;
        default:   res = cur;
      endcase
    end
    return res;
  endfunction

  // Solenoid drives high in high gear and while shifting up
  function automatic logic solenoid_high(input gear_t g);
    return (g == GEAR_HIGH) || (g == GEAR_UP);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/dgst_ifs.sv =====
// Valid/ready channel interfaces for the dual gear shift tracker.
// Depends on nothing; the top level instantiates them as ports.
`timescale 1ns / 1ps
`default_nettype none

interface dgst_in_if #(
  parameter int SENSOR_BITS = 12
) ();
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic                   requested_high;
  logic [SENSOR_BITS-1:0] left_shifter_pos;
  logic [SENSOR_BITS-1:0] right_shifter_pos;

  modport source (output valid, req_type, requested_high, left_shifter_pos,
                  right_shifter_pos, input ready);
  modport sink   (input valid, req_type, requested_high, left_shifter_pos,
                  right_shifter_pos, output ready);
endinterface

interface dgst_out_if ();
  logic       valid;
  logic       ready;
  logic [1:0] left_status;
  logic [1:0] right_status;
  logic       left_solenoid_high;
  logic       right_solenoid_high;
  logic [1:0] loop_select;

  modport source (output valid, left_status, right_status, left_solenoid_high,
                  right_solenoid_high, loop_select, input ready);
  modport sink   (input valid, left_status, right_status, left_solenoid_high,
                  right_solenoid_high, loop_select, output ready);
endinterface

`default_nettype wire

// ===== hdl/dual_gear_shift_tracker_top.sv =====
// Dual gear shift tracker, top level.
// Uses dgst_pkg and the channel interfaces in dgst_ifs.sv.
`timescale 1ns / 1ps
`default_nettype none

// Tracks the gear of a left and right shifter. Every input item (a gear request
// or a shifter position sample) gives exactly one result item carrying both
// side states, both solenoid commands and the held controller index. Items
// flow through two registers: an input register, then the result register
// that is loaded together with the gear state. One item is taken every cycle
// as long as the result side keeps up. The compare-and-update path between
// the two registers (per side one add of the clear thresholds with a compare
// for the index, and two compares for shift completion) sets the clock.
// Configuration writes land at once and must be made only while no item is in
// flight. Reset clears the gear states, the held index and the thresholds to
// their power-on values (clutch off, clear points at 1024 and 3072).
module dual_gear_shift_tracker_top #(
  parameter int SENSOR_BITS = 12
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [dgst_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [SENSOR_BITS-1:0]          cfg_data,
  dgst_in_if.sink                              in_ch,
  dgst_out_if.source                           out_ch
);

  localparam logic [31:0] CLEAR_LOW_RST  = 32'd1024;
  localparam logic [31:0] CLEAR_HIGH_RST = 32'd3072;

  // Configuration registers
  logic                   clutch_mode;
  logic [SENSOR_BITS-1:0] left_clear_low;
  logic [SENSOR_BITS-1:0] left_clear_high;
  logic [SENSOR_BITS-1:0] right_clear_low;
  logic [SENSOR_BITS-1:0] right_clear_high;

  // Input register
  logic                   s1_valid;
  logic                   s1_req_type;
  logic                   s1_want_high;
  logic [SENSOR_BITS-1:0] s1_lpos;
  logic [SENSOR_BITS-1:0] s1_rpos;

  // Tracker state
  dgst_pkg::gear_t left_gear, left_gear_next;
  dgst_pkg::gear_t right_gear, right_gear_next;
  logic [1:0]      held_sel, held_sel_next;

  // Result register
  logic out_valid;

  logic s1_fire;
  logic s1_advance;
  logic left_is_high, right_is_high;

  // ---------------------------------------------------------------------
  // Configuration: direct write, unknown indexes dropped
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      clutch_mode      <= 1'b0;
      left_clear_low   <= CLEAR_LOW_RST[SENSOR_BITS-1:0];
      left_clear_high  <= CLEAR_HIGH_RST[SENSOR_BITS-1:0];
      right_clear_low  <= CLEAR_LOW_RST[SENSOR_BITS-1:0];
      right_clear_high <= CLEAR_HIGH_RST[SENSOR_BITS-1:0];
    end else if (cfg_we) begin
      unique case (cfg_index)
        dgst_pkg::CFG_CLUTCH_MODE:      clutch_mode      <= cfg_data[0];
        dgst_pkg::CFG_LEFT_CLEAR_LOW:   left_clear_low   <= cfg_data;
        dgst_pkg::CFG_LEFT_CLEAR_HIGH:  left_clear_high  <= cfg_data;
        dgst_pkg::CFG_RIGHT_CLEAR_LOW:  right_clear_low  <= cfg_data;
        dgst_pkg::CFG_RIGHT_CLEAR_HIGH: right_clear_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake: the input register advances whenever the result register
  // is empty or being drained this cycle.
  // ---------------------------------------------------------------------
  assign s1_advance  = !out_valid || out_ch.ready;
  assign s1_fire     = s1_valid && s1_advance;
  assign in_ch.ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  // Payload needs no reset; hold while stalled
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_req_type  <= in_ch.req_type;
      s1_want_high <= in_ch.requested_high;
      s1_lpos      <= in_ch.left_shifter_pos;
      s1_rpos      <= in_ch.right_shifter_pos;
    end
  end

  // ---------------------------------------------------------------------
  // Per-side helpers
  // ---------------------------------------------------------------------
  // A side reads high when in any state but low and 2*pos is not below lo+hi
  function automatic logic side_high(input logic [SENSOR_BITS-1:0] pos,
                                     input logic [SENSOR_BITS-1:0] lo,
                                     input logic [SENSOR_BITS-1:0] hi,
                                     input dgst_pkg::gear_t g);
    logic [SENSOR_BITS:0] twice_pos;
    logic [SENSOR_BITS:0] sum;
    twice_pos = {pos, 1'b0};
    sum       = {1'b0, lo} + {1'b0, hi};
    return !(twice_pos < sum) && (g != dgst_pkg::GEAR_LOW);
  endfunction

  // Complete a shift once the reading passes its clear point
  function automatic dgst_pkg::gear_t finish_shift(input logic [SENSOR_BITS-1:0] pos,
                                                   input logic [SENSOR_BITS-1:0] lo,
                                                   input logic [SENSOR_BITS-1:0] hi,
                                                   input dgst_pkg::gear_t g);
    dgst_pkg::gear_t res;
    res = g;
    if (g == dgst_pkg::GEAR_UP && pos > hi)        res = dgst_pkg::GEAR_HIGH;
    else if (g == dgst_pkg::GEAR_DOWN && pos < lo) res = dgst_pkg::GEAR_LOW;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Next state: index pick uses the states from before any completion
  // ---------------------------------------------------------------------
  assign left_is_high  = side_high(s1_lpos, left_clear_low, left_clear_high, left_gear);
  assign right_is_high = side_high(s1_rpos, right_clear_low, right_clear_high, right_gear);

  always_comb begin
    left_gear_next  = left_gear;
    right_gear_next = right_gear;
    held_sel_next   = held_sel;
    case (dgst_pkg::req_t'(s1_req_type))
      dgst_pkg::REQ_GEAR: begin
        left_gear_next  = dgst_pkg::next_gear(s1_want_high, clutch_mode, left_gear);
        right_gear_next = dgst_pkg::next_gear(s1_want_high, clutch_mode, right_gear);
      end
      dgst_pkg::REQ_SAMPLE: begin
        held_sel_next   = {left_is_high, right_is_high};
        left_gear_next  = finish_shift(s1_lpos, left_clear_low, left_clear_high,
                                       left_gear);
        right_gear_next = finish_shift(s1_rpos, right_clear_low, right_clear_high,
                                       right_gear);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_gear  <= dgst_pkg::GEAR_LOW;
      right_gear <= dgst_pkg::GEAR_LOW;
      held_sel   <= 2'd0;
    end else if (s1_fire) begin
      left_gear  <= left_gear_next;
      right_gear <= right_gear_next;
      held_sel   <= held_sel_next;
    end
  end

  // ---------------------------------------------------------------------
  // Result register: the state registers double as its payload
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  assign out_ch.valid               = out_valid;
  assign out_ch.left_status         = left_gear;
  assign out_ch.right_status        = right_gear;
  assign out_ch.left_solenoid_high  = dgst_pkg::solenoid_high(left_gear);
  assign out_ch.right_solenoid_high = dgst_pkg::solenoid_high(right_gear);
  assign out_ch.loop_select         = held_sel;

`ifndef ASSERT_OFF
  // A gear request leaves the held controller index alone
  a_req_keeps_sel: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_req_type == dgst_pkg::REQ_GEAR) |=> $stable(held_sel))
    else $error("held index changed on a gear request");

  // A side that was in low gear can never report high in the index (checked on the left side)
  a_low_not_high: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_req_type == dgst_pkg::REQ_SAMPLE &&
     left_gear == dgst_pkg::GEAR_LOW) |=> !held_sel[1])
    else $error("left side in low gear reported high");

  // In clutch mode an in-gear side goes straight to a gear (checked on the right side)
  a_clutch_direct: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_req_type == dgst_pkg::REQ_GEAR && clutch_mode &&
     (right_gear == dgst_pkg::GEAR_LOW || right_gear == dgst_pkg::GEAR_HIGH))
    |=> (right_gear == dgst_pkg::GEAR_LOW || right_gear == dgst_pkg::GEAR_HIGH))
    else $error("clutch-mode request left right side shifting");

  // A stalled result must not let the state move underneath it
  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |=> ($stable(left_gear) && $stable(right_gear)))
    else $error("state moved while result stalled");
`endif

endmodule

`default_nettype wire
